// ===== rtl/b2a_pkg.sv =====
// shared types, codes and lookup functions for the byte to ascii formatter
package b2a_pkg;

    // format selector codes
    localparam logic [2:0] OP_OCT      = 3'd0;
    localparam logic [2:0] OP_UDEC     = 3'd1;
    localparam logic [2:0] OP_HEX      = 3'd2;
    localparam logic [2:0] OP_TWOS     = 3'd3;
    localparam logic [2:0] OP_SIGN_MAG = 3'd4;

    // ascii codes for the sign characters and the digit zero
    localparam logic [6:0] CHAR_PLUS  = 7'h2B;
    localparam logic [6:0] CHAR_MINUS = 7'h2D;
    localparam logic [6:0] CHAR_ZERO  = 7'h30;
    // 'A' minus ten
    localparam logic [6:0] CHAR_HEX_BASE = 7'h37;

    // sign bit of the input byte
    localparam logic [7:0] SIGN_MASK = 8'h80;

    // digit places, most significant first
    localparam logic [1:0] POS_FIRST = 2'd0;
    localparam logic [1:0] POS_MID   = 2'd1;
    localparam logic [1:0] POS_LAST  = 2'd2;

    typedef enum logic [1:0] {
        RADIX_OCT,
        RADIX_DEC,
        RADIX_HEX
    } radix_t;

    // weight of a digit place for a given radix
    function automatic logic [7:0] place_weight(radix_t radix, logic [1:0] pos);
        logic [7:0] w;
        w = 8'd1;
        case (radix)
            RADIX_OCT: begin
                case (pos)
                    POS_FIRST: w = 8'd64;
                    POS_MID:   w = 8'd8;
                    default:   w = 8'd1;
                endcase
            end
            RADIX_DEC: begin
                case (pos)
                    POS_FIRST: w = 8'd100;
                    POS_MID:   w = 8'd10;
                    default:   w = 8'd1;
                endcase
            end
            RADIX_HEX: begin
                case (pos)
                    POS_MID: w = 8'd16;
                    default: w = 8'd1;
                endcase
            end
            default: w = 8'd1;
        endcase
        return w;
    endfunction

    // ascii code of one digit, upper-case hex letters
    function automatic logic [6:0] digit_char(logic [3:0] d);
        logic [6:0] c;
        if (d < 4'd10) begin
            c = CHAR_ZERO + {3'd0, d};
        end else begin
            c = CHAR_HEX_BASE + {3'd0, d};
        end
        return c;
    endfunction

endpackage

// ===== rtl/byte_to_ascii_radix_formatter.sv =====
// byte to ascii formatter: sequencer around one shared compare-subtract unit
// a signed format emits a sign character first, and leading zero places are skipped
// throughput: one byte at a time; each result waits in an output register while
//   the next digit works
// reset: aresetn synchronous active low, returns to idle with no result pending
module byte_to_ascii_radix_formatter (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [2:0] s_op,
    input  logic [7:0] s_value,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [6:0] m_char_code,
    output logic       m_last
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SIGN,
        S_DIV,
        S_EMIT
    } state_t;

    state_t             state_reg, state_next;
    b2a_pkg::radix_t    radix_reg, radix_next;
    logic [1:0]         pos_reg, pos_next;
    logic [7:0]         mag_reg, mag_next;
    logic [3:0]         digit_reg, digit_next;
    logic               started_reg, started_next;
    logic               neg_reg, neg_next;
    logic               m_valid_reg, m_valid_next;
    logic [6:0]         m_char_reg, m_char_next;
    logic               m_last_reg, m_last_next;

    logic [7:0]         weight;
    logic               fits;
    logic               out_free;
    logic               in_xact;

    assign s_ready     = (state_reg == S_IDLE);
    assign m_valid     = m_valid_reg;
    assign m_char_code = m_char_reg;
    assign m_last      = m_last_reg;

    assign in_xact  = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    // shared compare-subtract unit
    assign weight = b2a_pkg::place_weight(radix_reg, pos_reg);
    assign fits   = (mag_reg >= weight);

    // sequencer next-state logic
    always_comb begin
        state_next   = state_reg;
        radix_next   = radix_reg;
        pos_next     = pos_reg;
        mag_next     = mag_reg;
        digit_next   = digit_reg;
        started_next = started_reg;
        neg_next     = neg_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_char_next  = m_char_reg;
        m_last_next  = m_last_reg;

        case (state_reg)
            S_IDLE: begin
                digit_next   = 4'd0;
                started_next = 1'b0;
                pos_next     = b2a_pkg::POS_FIRST;
                mag_next     = s_value;
                neg_next     = (s_value & b2a_pkg::SIGN_MASK) != 8'd0;
                if (in_xact) begin
                    case (s_op)
                        b2a_pkg::OP_OCT: begin
                            radix_next = b2a_pkg::RADIX_OCT;
                            state_next = S_DIV;
                        end
                        b2a_pkg::OP_UDEC: begin
                            radix_next = b2a_pkg::RADIX_DEC;
                            state_next = S_DIV;
                        end
                        b2a_pkg::OP_HEX: begin
                            radix_next = b2a_pkg::RADIX_HEX;
                            pos_next   = b2a_pkg::POS_MID;
                            state_next = S_DIV;
                        end
                        b2a_pkg::OP_TWOS: begin
                            radix_next = b2a_pkg::RADIX_DEC;
                            if (s_value[7]) begin
                                mag_next = ~s_value + 8'd1;
                            end
                            state_next = S_SIGN;
                        end
                        b2a_pkg::OP_SIGN_MAG: begin
                            radix_next = b2a_pkg::RADIX_DEC;
                            mag_next   = {1'b0, s_value[6:0]};
                            state_next = S_SIGN;
                        end
                        default: begin
                            // unused selector: transaction dropped
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_SIGN: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_char_next  = neg_reg ? b2a_pkg::CHAR_MINUS : b2a_pkg::CHAR_PLUS;
                    m_last_next  = 1'b0;
                    state_next   = S_DIV;
                end
            end
            S_DIV: begin
                if (fits) begin
                    mag_next   = mag_reg - weight;
                    digit_next = digit_reg + 4'd1;
                end else if (digit_reg != 4'd0 || started_reg
                             || pos_reg == b2a_pkg::POS_LAST) begin
                    state_next = S_EMIT;
                end else begin
                    // leading zero place, skip it
                    pos_next = pos_reg + 2'd1;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_char_next  = b2a_pkg::digit_char(digit_reg);
                    m_last_next  = (pos_reg == b2a_pkg::POS_LAST);
                    digit_next   = 4'd0;
                    started_next = 1'b1;
                    if (pos_reg == b2a_pkg::POS_LAST) begin
                        state_next = S_IDLE;
                    end else begin
                        pos_next   = pos_reg + 2'd1;
                        state_next = S_DIV;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and output registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
        radix_reg   <= radix_next;
        pos_reg     <= pos_next;
        mag_reg     <= mag_next;
        digit_reg   <= digit_next;
        started_reg <= started_next;
        neg_reg     <= neg_next;
        m_char_reg  <= m_char_next;
        m_last_reg  <= m_last_next;
    end

`ifndef SYNTHESIS
    // a digit leaves only once the remainder is below the place weight
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_EMIT) |-> (mag_reg < weight))
        else $error("digit emitted with remainder not below place weight");

    // back in idle, any pending character closes the text
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && state_reg == S_IDLE) |-> m_last_reg)
        else $error("idle while a non-final character is pending");

    // a legal format keeps the input closed on the next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_xact && s_op <= b2a_pkg::OP_SIGN_MAG) |=> !s_ready)
        else $error("input reopened right after a legal transaction");
`endif

endmodule
